[rtl/tgq_pkg.sv]
// ============================================================================
// tgq_pkg
// Shared types, field widths and codes for the tilt gesture qualifier.
// ============================================================================
package tgq_pkg;

   // slot geometry
   localparam int SLOTS  = 4;
   localparam int SLOT_W = 2;

   // field widths
   localparam int ANGLE_W    = 9;
   localparam int DEG_W      = 8;
   localparam int COUNT_W    = 8;
   localparam int SLOT_CNT_W = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 8;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 8;

   // register reset values
   localparam logic [SLOT_CNT_W-1:0] SLOT_COUNT_RST = 3'd0;
   localparam logic [DEG_W-1:0]      THRESHOLD_RST  = 8'd30;
   localparam logic [DEG_W-1:0]      REARM_RST      = 8'd10;
   localparam logic [COUNT_W-1:0]    SUSTAIN_RST    = 8'd3;
   localparam logic [COUNT_W-1:0]    HIGHLIGHT_RST  = 8'd20;

   // register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SLOT_COUNT = 3'd0,
      CSR_THRESHOLD  = 3'd1,
      CSR_REARM      = 3'd2,
      CSR_SUSTAIN    = 3'd3,
      CSR_HIGHLIGHT  = 3'd4
   } csr_index_type;

   // item kinds
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_CLICK = 1'b1;

   // direction slots
   localparam logic [SLOT_W-1:0] SLOT_UP    = 2'd0;
   localparam logic [SLOT_W-1:0] SLOT_DOWN  = 2'd1;
   localparam logic [SLOT_W-1:0] SLOT_LEFT  = 2'd2;
   localparam logic [SLOT_W-1:0] SLOT_RIGHT = 2'd3;

   typedef struct packed {
      logic [SLOT_CNT_W-1:0] slot_count;
      logic [DEG_W-1:0]      threshold_degrees;
      logic [DEG_W-1:0]      rearm_degrees;
      logic [COUNT_W-1:0]    sustain_ticks;
      logic [COUNT_W-1:0]    highlight_ticks;
   } cfg_type;

   typedef struct packed {
      logic                     cmd;
      logic signed [ANGLE_W-1:0] pitch_deg;
      logic signed [ANGLE_W-1:0] roll_deg;
      logic [SLOT_W-1:0]        button_slot;
   } item_type;

   typedef struct packed {
      logic                       armed_flag;
      logic [SLOTS-1:0][COUNT_W-1:0] sustain_count;
      logic [SLOTS-1:0][COUNT_W-1:0] highlight_left;
   } state_type;

   typedef struct packed {
      logic              trigger_valid;
      logic [SLOT_W-1:0] trigger_slot;
      logic              haptic_pulse;
      logic [SLOTS-1:0]  highlight_mask;
      logic              armed;
   } result_type;

endpackage

[rtl/tgq_csr.sv]
// ============================================================================
// tgq_csr
// Configuration register file, written through a plain write port.
// ============================================================================
module tgq_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [tgq_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [tgq_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output tgq_pkg::cfg_type                  cfg
);
   import tgq_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // decode the write into the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_SLOT_COUNT: cfg_in.slot_count        = csr_wdata[SLOT_CNT_W-1:0];
            CSR_THRESHOLD:  cfg_in.threshold_degrees = csr_wdata[DEG_W-1:0];
            CSR_REARM:      cfg_in.rearm_degrees     = csr_wdata[DEG_W-1:0];
            CSR_SUSTAIN:    cfg_in.sustain_ticks     = csr_wdata[COUNT_W-1:0];
            CSR_HIGHLIGHT:  cfg_in.highlight_ticks   = csr_wdata[COUNT_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slot_count        <= SLOT_COUNT_RST;
         cfg_ff.threshold_degrees <= THRESHOLD_RST;
         cfg_ff.rearm_degrees     <= REARM_RST;
         cfg_ff.sustain_ticks     <= SUSTAIN_RST;
         cfg_ff.highlight_ticks   <= HIGHLIGHT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/tgq_step.sv]
// ============================================================================
// tgq_step
// Next-state and result logic for one tick or click.
// ============================================================================
module tgq_step (
   input  tgq_pkg::cfg_type    cfg,
   input  tgq_pkg::state_type  state,
   input  tgq_pkg::item_type   item,
   output tgq_pkg::state_type  state_next,
   output tgq_pkg::result_type result
);
   import tgq_pkg::*;

   localparam int WIDE_W = ANGLE_W + 1;

   logic signed [WIDE_W-1:0] pitch_w;
   logic signed [WIDE_W-1:0] roll_w;
   logic signed [WIDE_W-1:0] th_w;
   logic signed [WIDE_W-1:0] rb_w;
   logic signed [WIDE_W-1:0] pitch_abs;
   logic signed [WIDE_W-1:0] roll_abs;
   logic [SLOTS-1:0]         in_use;
   logic [SLOTS-1:0]         active;
   logic [SLOTS-1:0]         reached;
   logic                     found;
   logic [SLOT_W-1:0]        first;
   logic                     click_ok;

   // widened angles and limits
   always_comb begin
      pitch_w   = WIDE_W'(item.pitch_deg);
      roll_w    = WIDE_W'(item.roll_deg);
      th_w      = signed'({{(WIDE_W-DEG_W){1'b0}}, cfg.threshold_degrees});
      rb_w      = signed'({{(WIDE_W-DEG_W){1'b0}}, cfg.rearm_degrees});
      pitch_abs = pitch_w[WIDE_W-1] ? -pitch_w : pitch_w;
      roll_abs  = roll_w[WIDE_W-1]  ? -roll_w  : roll_w;
      active[SLOT_UP]    = pitch_w < -th_w;
      active[SLOT_DOWN]  = pitch_w > th_w;
      active[SLOT_LEFT]  = roll_w  < -th_w;
      active[SLOT_RIGHT] = roll_w  > th_w;
      for (int i = 0; i < SLOTS; i++) begin
         in_use[i] = {1'b0, SLOT_W'(i)} < cfg.slot_count;
      end
      click_ok = {1'b0, item.button_slot} < cfg.slot_count;
   end

   // state update and result
   always_comb begin
      state_next = state;
      result     = '0;
      reached    = '0;
      found      = 1'b0;
      first      = SLOT_UP;
      if (item.cmd == CMD_CLICK) begin
         if (click_ok) begin
            result.trigger_valid = 1'b1;
            result.trigger_slot  = item.button_slot;
            state_next.highlight_left[item.button_slot] = cfg.highlight_ticks;
         end
      end else if (cfg.slot_count != '0) begin
         // highlight countdown over slots in use
         for (int i = 0; i < SLOTS; i++) begin
            if (in_use[i] && state.highlight_left[i] != '0) begin
               state_next.highlight_left[i] = state.highlight_left[i] - 1'b1;
            end
         end
         if (!state.armed_flag) begin
            // re-arm when both angles are inside the band
            if (pitch_abs < rb_w && roll_abs < rb_w) begin
               state_next.armed_flag    = 1'b1;
               state_next.sustain_count = '0;
            end
         end else begin
            // saturating sustain counters
            for (int i = 0; i < SLOTS; i++) begin
               if (!active[i]) begin
                  state_next.sustain_count[i] = '0;
               end else if (state.sustain_count[i] < cfg.sustain_ticks) begin
                  state_next.sustain_count[i] = state.sustain_count[i] + 1'b1;
               end
               reached[i] = state_next.sustain_count[i] >= cfg.sustain_ticks;
            end
            // lowest-numbered sustained direction wins
            for (int i = SLOTS - 1; i >= 0; i--) begin
               if (reached[i]) begin
                  found = 1'b1;
                  first = SLOT_W'(i);
               end
            end
            if (found) begin
               state_next.sustain_count = '0;
               if (in_use[first]) begin
                  result.trigger_valid = 1'b1;
                  result.trigger_slot  = first;
                  result.haptic_pulse  = 1'b1;
                  state_next.highlight_left[first] = cfg.highlight_ticks;
                  state_next.armed_flag = 1'b0;
               end
            end
         end
      end
      for (int i = 0; i < SLOTS; i++) begin
         result.highlight_mask[i] = state_next.highlight_left[i] != '0;
      end
      result.armed = state_next.armed_flag;
   end

endmodule

[rtl/tilt_gesture_qualifier_core.sv]
// ============================================================================
// tilt_gesture_qualifier_core
// Qualifies wrist tilt gestures and button clicks into shortcut triggers.
// ============================================================================
//   channel  direction  signals                     payload
//   req      in         req_tvalid/tready/tdata/tuser  angles, slot; tuser = cmd
//   rsp      out        rsp_tvalid/tready/tdata/tuser  slot, haptic, mask, armed
//   csr      in         csr_we/addr/wdata              five config registers
//
// one item per cycle sustained while rsp is not stalled; an item is held in
// the input register and evaluated against the gesture state into the result
// register. rsp valid rises when the item passes from input to result register.
// synchronous active-high reset clears the gesture state, config and valids.
// a stalled rsp holds its result; the input register keeps accepting until full.
module tilt_gesture_qualifier_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [8:0] pitch_deg, [17:9] roll_deg, [19:18] button_slot, [23:20] zero
   input  logic [tgq_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] cmd
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [1:0] trigger_slot, [2] haptic_pulse, [6:3] highlight_mask, [7] armed
   output logic [tgq_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [0] trigger_valid
   output logic                               rsp_tuser,
   input  logic                               csr_we,
   input  logic [tgq_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [tgq_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import tgq_pkg::*;

   cfg_type    cfg;
   item_type   req_item;
   item_type   item_ff;
   logic       item_valid_ff;
   logic       item_valid_in;
   state_type  state_ff;
   state_type  state_in;
   result_type result;
   result_type result_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       advance;
   logic       req_fire;

   tgq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // unpack the request
   always_comb begin
      req_item.cmd         = req_tuser;
      req_item.pitch_deg   = req_tdata[ANGLE_W-1:0];
      req_item.roll_deg    = req_tdata[2*ANGLE_W-1:ANGLE_W];
      req_item.button_slot = req_tdata[2*ANGLE_W+SLOT_W-1:2*ANGLE_W];
   end

   // handshake control
   assign advance       = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready    = !item_valid_ff || advance;
   assign req_fire      = req_tvalid && req_tready;
   assign item_valid_in = req_fire || (item_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && !rsp_tready);

   tgq_step u_step (
      .cfg        (cfg),
      .state      (state_ff),
      .item       (item_ff),
      .state_next (state_in),
      .result     (result)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= req_item;
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = result_ff.trigger_valid;
   assign rsp_tdata  = {result_ff.armed, result_ff.highlight_mask,
                        result_ff.haptic_pulse, result_ff.trigger_slot};

endmodule

[rtl/tgq_checker.sv]
// ============================================================================
// tgq_port_assertions
// Port-level checks on the result channel of the gesture qualifier.
// ============================================================================
module tgq_port_assertions (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [tgq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tuser
);
   import tgq_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp changed while stalled");

   // no trigger means slot and haptic are zero
   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[2:0] == 3'd0)
      else $error("slot or haptic set without trigger");

   // a haptic gesture always disarms
   a_haptic_disarms: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> rsp_tuser && !rsp_tdata[7])
      else $error("haptic pulse while armed");

   // nothing is presented right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind tilt_gesture_qualifier_core tgq_port_assertions u_tgq_port_assertions (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
